// ===== hw/rtl/gmte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmte_pkg
// shared codes and widths for the move time estimator
// ----------------------------------------------------------------------------
package gmte_pkg;
  localparam int IN_COORD_W = 24;
  localparam int IN_FEED_W  = 20;
  localparam int TIME_W     = 48;
  localparam int KIND_W     = 7;

  localparam logic [KIND_W-1:0] G_MOVE = 7'd1;
  localparam logic [KIND_W-1:0] G_ABS  = 7'd90;
  localparam logic [KIND_W-1:0] G_REL  = 7'd91;
  localparam logic [KIND_W-1:0] G_HOME = 7'd92;

  localparam int MOVE_THRESHOLD = 10;
  localparam int FEED_RESET     = 10000;
endpackage
`default_nettype wire

// ===== hw/rtl/gmte_sqdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmte_sqdiv
// bit-serial floor(sqrt(n)) followed by a restoring divide by the feed
// ----------------------------------------------------------------------------
module gmte_sqdiv import gmte_pkg::*; #(
  parameter int NW = 96,   // radicand width, even
  parameter int FW = 20
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] radicand,
  input  wire logic [FW-1:0] divisor,
  output logic               done,
  output logic [NW/2-1:0]    quotient
);
  localparam int RW = NW / 2;
  localparam int CW = $clog2(NW + 1);
  // remainder holds the root remainder and later the divide remainder
  localparam int AW = (RW + 2 > FW + 1) ? RW + 2 : FW + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SQRT = 3'b010,
    S_DIV  = 3'b100
  } st_t;

  st_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [AW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [FW-1:0] d_r;
  logic [RW+1:0] trial;
  logic [RW+1:0] tsub;
  logic [FW:0]   dsh;
  logic [FW:0]   dsub;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    done     = 1'b0;
    trial    = '0;
    tsub     = '0;
    dsh      = '0;
    dsub     = '0;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          st_nxt   = S_SQRT;
          cnt_nxt  = CW'(RW);
          n_nxt    = radicand;
          rem_nxt  = '0;
          root_nxt = '0;
        end
      end
      S_SQRT: begin
        // two bits of radicand per cycle
        trial = {rem_r[RW-1:0], n_r[NW-1 -: 2]};
        tsub  = trial - {root_r, 2'b01};
        n_nxt = {n_r[NW-3:0], 2'b00};
        if (!tsub[RW+1]) begin
          rem_nxt  = AW'(tsub);
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = AW'(trial);
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          st_nxt  = S_DIV;
          cnt_nxt = CW'(RW);
          rem_nxt = '0;
        end
      end
      S_DIV: begin
        // root register shifts out dividend, shifts in quotient
        dsh  = {rem_r[FW-1:0], root_r[RW-1]};
        dsub = dsh - {1'b0, d_r};
        if (!dsub[FW]) begin
          rem_nxt  = AW'(dsub);
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = AW'(dsh);
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          st_nxt = S_IDLE;
          done   = 1'b1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign quotient = root_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (start && st_r == S_IDLE) d_r <= divisor;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/gcode_move_time_estimator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcode_move_time_estimator
// tracks tool position, mode, feed and shutter from decoded g-code commands
// and accumulates move time as length over feed
// ----------------------------------------------------------------------------
// flow: non-move commands go from update to output; a G1 whose summed axis distance is
// within MOVE_THRESHOLD (10) goes to output on loading the serial square; a longer
// G1 runs the serial squares, the square root and the divide before the output
// throughput: one command at a time; the next is taken once the result is accepted
// reset: synchronous active-low; positions, offsets, time cleared, feed 10000
module gcode_move_time_estimator import gmte_pkg::*; #(
  parameter int COORD_BITS     = 24,
  parameter int FEED_BITS      = 20,
  parameter int TIME_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // has_g, kind, has_x, x_word, has_y, y_word, has_z, z_word, has_f,
  // feed_word, has_e, shutter_word, zero pad
  input  wire logic [111:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pos_x, pos_y, pos_z, total_time, shutter_state, relative_mode, saturated,
  // zero pad
  output logic [127:0]     out_tdata
);
  localparam int CB  = COORD_BITS;
  localparam int MW  = CB + 1;              // magnitude width
  localparam int SW  = 2 * MW + 2;          // sum of squares width
  localparam int NW0 = SW + 2 * TIME_FRAC_BITS;
  localparam int NW  = NW0 + (NW0 % 2);
  localparam int RW  = NW / 2;
  localparam int MCW = $clog2(MW + 1);
  localparam logic signed [CB:0] CMAX = (CB+1)'((64'd1 << (CB - 1)) - 1);
  localparam logic signed [CB:0] CMIN = -CMAX - 1;
  localparam logic [FEED_BITS-1:0] FMAX = '1;
  localparam logic [FEED_BITS-1:0] FRST =
    (FEED_RESET > (64'd1 << FEED_BITS) - 1) ? FMAX : FEED_BITS'(FEED_RESET);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UPD  = 6'b000010,
    S_MUL  = 6'b000100,
    S_ROOT = 6'b001000,
    S_WAIT = 6'b010000,
    S_OUT  = 6'b100000
  } st_t;

  st_t st_r;
  logic signed [CB-1:0] cur_r [3];
  logic signed [CB-1:0] prev_r [3];
  logic signed [CB-1:0] home_r [3];
  logic [FEED_BITS-1:0] feed_r;
  logic                 shut_r, incr_r, sat_r;
  logic [TIME_W-1:0]    time_r;
  logic [111:0]         cmd_r;
  logic [MW-1:0]        mag_r [3];
  logic [1:0]           ax_r;
  logic [MCW-1:0]       mcnt_r;
  logic [MW-1:0]        mq_r;
  logic [SW-1:0]        acc_r;
  logic                 sq_start;
  logic                 sq_done;
  logic [RW-1:0]        sq_q;

  logic                 c_g, c_hf, c_he, c_sh;
  logic [KIND_W-1:0]    c_kind;
  logic [2:0]           c_h;
  logic [IN_FEED_W-1:0] c_f;

  assign c_g    = cmd_r[0];
  assign c_kind = cmd_r[7:1];
  assign c_h    = {cmd_r[58], cmd_r[33], cmd_r[8]};
  assign c_hf   = cmd_r[83];
  assign c_f    = cmd_r[103:84];
  assign c_he   = cmd_r[104];
  assign c_sh   = cmd_r[105];

  // input words at input coordinate width, widened and clamped below
  logic signed [IN_COORD_W-1:0] c_raw [3];
  assign c_raw[0] = cmd_r[32:9];
  assign c_raw[1] = cmd_r[57:34];
  assign c_raw[2] = cmd_r[82:59];

  // new positions and clamp for G1 and G92
  logic signed [CB+IN_COORD_W:0] sum_w [3];
  logic signed [CB-1:0] newpos [3];
  logic signed [CB-1:0] newhome [3];
  logic [2:0] psat, hsat;
  logic signed [CB+IN_COORD_W:0] hw [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_w[i] = (incr_r ? (CB+IN_COORD_W+1)'(cur_r[i]) : (CB+IN_COORD_W+1)'(home_r[i]))
               + (CB+IN_COORD_W+1)'(c_raw[i]);
      psat[i] = 1'b0;
      if (sum_w[i] > (CB+IN_COORD_W+1)'(CMAX)) begin
        newpos[i] = CB'(CMAX); psat[i] = 1'b1;
      end else if (sum_w[i] < (CB+IN_COORD_W+1)'(CMIN)) begin
        newpos[i] = CB'(CMIN); psat[i] = 1'b1;
      end else begin
        newpos[i] = CB'(sum_w[i]);
      end
      hw[i] = (CB+IN_COORD_W+1)'(c_raw[i]);
      hsat[i] = 1'b0;
      if (hw[i] > (CB+IN_COORD_W+1)'(CMAX)) begin
        newhome[i] = CB'(CMAX); hsat[i] = 1'b1;
      end else if (hw[i] < (CB+IN_COORD_W+1)'(CMIN)) begin
        newhome[i] = CB'(CMIN); hsat[i] = 1'b1;
      end else begin
        newhome[i] = CB'(hw[i]);
      end
    end
  end

  // distances after update
  logic signed [CB:0] dl [3];
  logic [MW-1:0] dm [3];
  logic [MW+1:0] msum;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dl[i] = (CB+1)'(cur_r[i]) - (CB+1)'(prev_r[i]);
      dm[i] = dl[i][CB] ? MW'(-dl[i]) : MW'(dl[i]);
    end
    msum = (MW+2)'(dm[0]) + (MW+2)'(dm[1]) + (MW+2)'(dm[2]);
  end

  logic [TIME_W:0] tsum;
  assign tsum = (TIME_W+1)'(time_r) +
    ((RW > TIME_W) ? (TIME_W+1)'(sq_q > RW'({TIME_W{1'b1}}) ? {TIME_W{1'b1}} : sq_q)
                   : (TIME_W+1)'(sq_q));

  // radicand: S shifted by 2*frac bits
  logic [NW-1:0] rad;
  assign rad = NW'(acc_r) << (2 * TIME_FRAC_BITS);

  assign sq_start = (st_r == S_ROOT);

  gmte_sqdiv #(.NW(NW), .FW(FEED_BITS)) u_sqdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (rad),
    .divisor  (feed_r),
    .done     (sq_done),
    .quotient (sq_q)
  );

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);

  always_comb begin
    out_tdata = '0;
    out_tdata[23:0]   = 24'(cur_r[0]);
    out_tdata[47:24]  = 24'(cur_r[1]);
    out_tdata[71:48]  = 24'(cur_r[2]);
    out_tdata[119:72] = time_r;
    out_tdata[120]    = shut_r;
    out_tdata[121]    = incr_r;
    out_tdata[122]    = sat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      feed_r <= FRST;
      shut_r <= 1'b0;
      incr_r <= 1'b0;
      sat_r  <= 1'b0;
      time_r <= '0;
      for (int i = 0; i < 3; i++) begin
        cur_r[i]  <= '0;
        prev_r[i] <= '0;
        home_r[i] <= '0;
      end
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r <= in_tdata;
            sat_r <= 1'b0;
            st_r  <= S_UPD;
          end
        end
        S_UPD: begin
          st_r <= S_OUT;
          if (c_g) begin
            if (c_kind == G_MOVE) begin
              if (c_hf) begin
                if (c_f == '0) feed_r <= FEED_BITS'(1);
                else if ((IN_FEED_W > FEED_BITS) &&
                         ((32'(c_f) >> FEED_BITS) != 0)) feed_r <= FMAX;
                else feed_r <= FEED_BITS'(c_f);
              end
              if (c_he) shut_r <= c_sh;
              for (int i = 0; i < 3; i++)
                if (c_h[i]) cur_r[i] <= newpos[i];
              sat_r <= |(psat & c_h);
              st_r  <= S_MUL;
              ax_r  <= 2'd0;
              acc_r <= '0;
            end else if (c_kind == G_ABS) begin
              incr_r <= 1'b0;
            end else if (c_kind == G_REL) begin
              incr_r <= 1'b1;
            end else if (c_kind == G_HOME) begin
              for (int i = 0; i < 3; i++)
                if (c_h[i]) begin
                  home_r[i] <= newhome[i];
                  cur_r[i]  <= '0;
                end
              sat_r <= |(hsat & c_h);
            end
          end
          mcnt_r <= '0;
        end
        S_MUL: begin
          // shift-add square, one multiplier bit per cycle
          if (mcnt_r == '0) begin
            mag_r[0] <= dm[0];
            mag_r[1] <= dm[1];
            mag_r[2] <= dm[2];
            mq_r     <= dm[ax_r];
            mcnt_r   <= MCW'(1);
            if (ax_r == 2'd0 && msum <= (MW+2)'(MOVE_THRESHOLD)) begin
              st_r <= S_OUT;
              for (int i = 0; i < 3; i++) prev_r[i] <= cur_r[i];
            end
          end else begin
            if (mq_r[0]) acc_r <= acc_r + (SW'(mag_r[ax_r]) << (mcnt_r - 1'b1));
            mq_r <= mq_r >> 1;
            if (mcnt_r == MCW'(MW)) begin
              mcnt_r <= '0;
              if (ax_r == 2'd2) st_r <= S_ROOT;
              else ax_r <= ax_r + 2'd1;
            end else begin
              mcnt_r <= mcnt_r + 1'b1;
            end
          end
        end
        S_ROOT: st_r <= S_WAIT;
        S_WAIT: begin
          if (sq_done) begin
            if (tsum[TIME_W] || ((RW > TIME_W) && (sq_q > RW'({TIME_W{1'b1}})))) begin
              time_r <= '1;
              sat_r  <= 1'b1;
            end else begin
              time_r <= tsum[TIME_W-1:0];
            end
            for (int i = 0; i < 3; i++) prev_r[i] <= cur_r[i];
            st_r <= S_OUT;
          end
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
